// ===== design/incremental_pid_position_balance_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ball position balancer
// Shorthand for clocked assertions that are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_PID_POSITION_BALANCE_ASSERT_SVH
`define INCREMENTAL_PID_POSITION_BALANCE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPPB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ippb_pkg.sv =====
// ----------------------------------------------------------------------------
// ippb_pkg
// Shared types and codes for the incremental PID ball position balancer.
// ----------------------------------------------------------------------------
package ippb_pkg;

  // Command issued with each tick's result.
  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_SET  = 2'd1,
    CMD_STOP = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_GAIN_P          = 3'd0,
    REG_GAIN_I          = 3'd1,
    REG_GAIN_D          = 3'd2,
    REG_TARGET_POSITION = 3'd3,
    REG_DEADBAND        = 3'd4,
    REG_DELTA_MAX       = 3'd5,
    REG_DELTA_MIN       = 3'd6
  } reg_idx_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0]        gain_p;
    logic [15:0]        gain_i;
    logic [15:0]        gain_d;
    logic signed [15:0] target_position;
    logic [14:0]        deadband;
    logic [14:0]        delta_max;
    logic signed [15:0] delta_min;
  } ippb_cfg_t;

  // Per-tick control that travels with the item down the pipeline.
  typedef struct packed {
    cmd_t               cmd;
    logic               move;
    logic               settled;
    logic signed [15:0] motor;
  } ippb_ctl_t;

  // Error stage result: the three PID error terms.
  typedef struct packed {
    ippb_ctl_t          ctl;
    logic signed [16:0] e_now;
    logic signed [17:0] e_diff1;
    logic signed [18:0] e_diff2;
  } ippb_err_t;

  // Multiply stage result: the three gain products in Q.16.
  typedef struct packed {
    ippb_ctl_t          ctl;
    logic signed [34:0] prod_p;
    logic signed [33:0] prod_i;
    logic signed [35:0] prod_d;
  } ippb_prod_t;

  // Delta stage result: clamped whole-step change.
  typedef struct packed {
    ippb_ctl_t          ctl;
    logic signed [15:0] delta;
  } ippb_dlt_t;

endpackage

// ===== design/incremental_pid_position_balance.sv =====
// ----------------------------------------------------------------------------
// incremental_pid_position_balance
// Incremental PID ball position balancer with deadband and frame-loss stop.
// ----------------------------------------------------------------------------
// Each input beat is one control tick and yields exactly one result beat. The
// block takes a new beat every clock cycle unless result back-pressure stalls
// it; a result crosses the four register stages (error terms, gain products,
// clamped delta, step target). Stages move independently, so input beats are
// still taken while a result waits, until the four stages are full. The step
// target feedback closes inside the last stage, so back-to-back ticks see each
// other's updates. Configuration writes are meant for idle periods only.
`include "incremental_pid_position_balance_assert.svh"

module incremental_pid_position_balance import ippb_pkg::*; #(
  parameter int STEP_LIMIT_MAX = 3200,
  parameter int STEP_LIMIT_MIN = -3200,
  parameter int SETTLE_LIMIT   = 20,
  parameter int LOSS_LIMIT     = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration write port.
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  // Input stream.
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,   // [15:0] ball_position, [31:16] motor_position
  input  logic                in_tuser,   // [0] frame_ok
  // Result stream.
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // [15:0] step_target, [16] settled, rest zero
  output logic [1:0]          out_tuser   // [1:0] command
);

  ippb_cfg_t          cfg_r;
  logic               settle_clr;
  logic               s1_vld, s1_rdy;
  ippb_err_t          s1_pl;
  logic               s2_vld, s2_rdy;
  ippb_prod_t         s2_pl;
  logic               s3_vld, s3_rdy;
  ippb_dlt_t          s3_pl;
  cmd_t               res_cmd;
  logic signed [15:0] res_target;
  logic               res_settled;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p          <= '0;
      cfg_r.gain_i          <= '0;
      cfg_r.gain_d          <= '0;
      cfg_r.target_position <= 16'sd6400;
      cfg_r.deadband        <= 15'd256;
      cfg_r.delta_max       <= 15'd100;
      cfg_r.delta_min       <= -16'sd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:          cfg_r.gain_p          <= cfg_data;
        REG_GAIN_I:          cfg_r.gain_i          <= cfg_data;
        REG_GAIN_D:          cfg_r.gain_d          <= cfg_data;
        REG_TARGET_POSITION: cfg_r.target_position <= $signed(cfg_data);
        REG_DEADBAND:        cfg_r.deadband        <= cfg_data[14:0];
        REG_DELTA_MAX:       cfg_r.delta_max       <= cfg_data[14:0];
        REG_DELTA_MIN:       cfg_r.delta_min       <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // A new setpoint restarts the settle count.
  assign settle_clr = cfg_we && (cfg_index == REG_TARGET_POSITION);

  ippb_err #(
    .SETTLE_LIMIT (SETTLE_LIMIT),
    .LOSS_LIMIT   (LOSS_LIMIT)
  ) u_err (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .settle_clr     (settle_clr),
    .up_vld         (in_tvalid),
    .up_rdy         (in_tready),
    .frame_ok       (in_tuser),
    .ball_position  ($signed(in_tdata[15:0])),
    .motor_position ($signed(in_tdata[31:16])),
    .dn_vld         (s1_vld),
    .dn_rdy         (s1_rdy),
    .dn_pl          (s1_pl)
  );

  ippb_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .up_vld (s1_vld),
    .up_rdy (s1_rdy),
    .up_pl  (s1_pl),
    .dn_vld (s2_vld),
    .dn_rdy (s2_rdy),
    .dn_pl  (s2_pl)
  );

  ippb_dlt u_dlt (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .up_vld (s2_vld),
    .up_rdy (s2_rdy),
    .up_pl  (s2_pl),
    .dn_vld (s3_vld),
    .dn_rdy (s3_rdy),
    .dn_pl  (s3_pl)
  );

  ippb_acc #(
    .STEP_LIMIT_MAX (STEP_LIMIT_MAX),
    .STEP_LIMIT_MIN (STEP_LIMIT_MIN)
  ) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_vld      (s3_vld),
    .up_rdy      (s3_rdy),
    .up_pl       (s3_pl),
    .out_vld     (out_tvalid),
    .out_rdy     (out_tready),
    .out_cmd     (res_cmd),
    .out_target  (res_target),
    .out_settled (res_settled)
  );

  // Result beat packing.
  assign out_tdata = {7'd0, res_settled, res_target};
  assign out_tuser = res_cmd;

  // Checks on pipeline occupancy and the delta clamp.
  `IPPB_ASSERT_NEXT(a_in_enters, in_tvalid && in_tready, s1_vld,
                    "accepted beat did not reach the error stage")
  `IPPB_ASSERT_NEXT(a_s1_holds, s1_vld && !s1_rdy, s1_vld && $stable(s1_pl),
                    "error stage lost or changed a stalled item")
  `IPPB_ASSERT_NOW(a_delta_bound,
                   s3_vld && (cfg_r.delta_min <= $signed({1'b0, cfg_r.delta_max})),
                   (s3_pl.delta <= $signed({1'b0, cfg_r.delta_max})) &&
                   (s3_pl.delta >= cfg_r.delta_min),
                   "clamped delta outside its bounds")

endmodule

// ===== design/ippb_err.sv =====
// ----------------------------------------------------------------------------
// ippb_err
// Error stage: forms the position error, runs the loss and settle counters,
// keeps the error history and registers the PID error terms.
// ----------------------------------------------------------------------------
module ippb_err import ippb_pkg::*; #(
  parameter int SETTLE_LIMIT = 20,
  parameter int LOSS_LIMIT   = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ippb_cfg_t          cfg,
  input  logic               settle_clr,
  input  logic               up_vld,
  output logic               up_rdy,
  input  logic               frame_ok,
  input  logic signed [15:0] ball_position,
  input  logic signed [15:0] motor_position,
  output logic               dn_vld,
  input  logic               dn_rdy,
  output ippb_err_t          dn_pl
);

  localparam logic [3:0] LossLim   = 4'(LOSS_LIMIT);
  localparam logic [7:0] SettleLim = 8'(SETTLE_LIMIT);

  logic               vld_r;
  ippb_err_t          pl_r, pl_nxt;
  logic signed [16:0] e_now_r, e_now_nxt;
  logic signed [16:0] e_last_r, e_last_nxt;
  logic [3:0]         lost_r, lost_nxt;
  logic [7:0]         settle_r, settle_nxt;
  logic signed [16:0] err;
  logic [16:0]        mag;
  logic               in_band;
  logic               fire;

  assign up_rdy = !vld_r || dn_rdy;
  assign fire   = up_vld && up_rdy;
  assign dn_vld = vld_r;
  assign dn_pl  = pl_r;

  // Error against the setpoint and its magnitude.
  assign err     = 17'(cfg.target_position) - 17'(ball_position);
  assign mag     = err[16] ? 17'(-err) : 17'(err);
  assign in_band = mag < {2'b00, cfg.deadband};

  // Tick decision and state update. The error before last is only ever
  // needed as the current last error, so it is not stored separately.
  always_comb begin
    e_now_nxt  = e_now_r;
    e_last_nxt = e_last_r;
    lost_nxt   = lost_r;
    settle_nxt = settle_r;
    pl_nxt.ctl.cmd   = CMD_NONE;
    pl_nxt.ctl.move  = 1'b0;
    pl_nxt.ctl.motor = motor_position;
    if (!frame_ok) begin
      lost_nxt = (lost_r == 4'hF) ? lost_r : lost_r + 4'd1;
      if (lost_nxt >= LossLim) begin
        pl_nxt.ctl.cmd = CMD_STOP;
      end
    end else begin
      lost_nxt       = '0;
      pl_nxt.ctl.cmd = CMD_SET;
      if (in_band) begin
        settle_nxt = (settle_r == 8'hFF) ? settle_r : settle_r + 8'd1;
      end else begin
        e_last_nxt      = e_now_r;
        e_now_nxt       = err;
        settle_nxt      = '0;
        pl_nxt.ctl.move = 1'b1;
      end
    end
    pl_nxt.ctl.settled = settle_nxt >= SettleLim;
    // Terms use the shifted history; they only matter on a move.
    pl_nxt.e_now   = err;
    pl_nxt.e_diff1 = 18'(err) - 18'(e_now_r);
    pl_nxt.e_diff2 = 19'(err) - (19'(e_now_r) <<< 1) + 19'(e_last_r);
  end

  // Control state and history registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      e_now_r  <= '0;
      e_last_r <= '0;
      lost_r   <= '0;
      settle_r <= '0;
    end else begin
      if (up_rdy) begin
        vld_r <= up_vld;
      end
      if (fire) begin
        e_now_r  <= e_now_nxt;
        e_last_r <= e_last_nxt;
        lost_r   <= lost_nxt;
        settle_r <= settle_nxt;
      end else if (settle_clr) begin
        settle_r <= '0;
      end
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (fire) begin
      pl_r <= pl_nxt;
    end
  end

endmodule

// ===== design/ippb_mul.sv =====
// ----------------------------------------------------------------------------
// ippb_mul
// Multiply stage: the three gains times their error terms, registered.
// ----------------------------------------------------------------------------
module ippb_mul import ippb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ippb_cfg_t  cfg,
  input  logic       up_vld,
  output logic       up_rdy,
  input  ippb_err_t  up_pl,
  output logic       dn_vld,
  input  logic       dn_rdy,
  output ippb_prod_t dn_pl
);

  logic       vld_r;
  ippb_prod_t pl_r, pl_nxt;
  logic       fire;

  assign up_rdy = !vld_r || dn_rdy;
  assign fire   = up_vld && up_rdy;
  assign dn_vld = vld_r;
  assign dn_pl  = pl_r;

  // Unsigned Q0.16 gains enter the products with a zero sign bit.
  always_comb begin
    pl_nxt.ctl    = up_pl.ctl;
    pl_nxt.prod_p = $signed({1'b0, cfg.gain_p}) * up_pl.e_diff1;
    pl_nxt.prod_i = $signed({1'b0, cfg.gain_i}) * up_pl.e_now;
    pl_nxt.prod_d = $signed({1'b0, cfg.gain_d}) * up_pl.e_diff2;
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  // Product registers.
  always_ff @(posedge clk) begin
    if (fire) begin
      pl_r <= pl_nxt;
    end
  end

endmodule

// ===== design/ippb_dlt.sv =====
// ----------------------------------------------------------------------------
// ippb_dlt
// Delta stage: sums the products, truncates toward zero to whole steps and
// clamps the change to the configured bounds.
// ----------------------------------------------------------------------------
module ippb_dlt import ippb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ippb_cfg_t  cfg,
  input  logic       up_vld,
  output logic       up_rdy,
  input  ippb_prod_t up_pl,
  output logic       dn_vld,
  input  logic       dn_rdy,
  output ippb_dlt_t  dn_pl
);

  logic               vld_r;
  ippb_dlt_t          pl_r, pl_nxt;
  logic               fire;
  logic signed [37:0] sum;
  logic signed [37:0] biased;
  logic signed [21:0] quot;
  logic signed [21:0] dmax;
  logic signed [21:0] dmin;
  logic signed [21:0] clip_hi;
  logic signed [21:0] clip_lo;

  assign up_rdy = !vld_r || dn_rdy;
  assign fire   = up_vld && up_rdy;
  assign dn_vld = vld_r;
  assign dn_pl  = pl_r;

  // Exact sum, then divide by 65536 rounding toward zero.
  assign sum    = 38'(up_pl.prod_p) + 38'(up_pl.prod_i) + 38'(up_pl.prod_d);
  assign biased = sum + (sum[37] ? 38'sd65535 : 38'sd0);
  assign quot   = biased[37:16];

  // Upper bound first, then the lower bound, which wins when they cross.
  assign dmax    = $signed({7'd0, cfg.delta_max});
  assign dmin    = 22'(cfg.delta_min);
  assign clip_hi = (quot > dmax) ? dmax : quot;
  assign clip_lo = (clip_hi < dmin) ? dmin : clip_hi;

  always_comb begin
    pl_nxt.ctl   = up_pl.ctl;
    pl_nxt.delta = clip_lo[15:0];
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  // Delta register.
  always_ff @(posedge clk) begin
    if (fire) begin
      pl_r <= pl_nxt;
    end
  end

endmodule

// ===== design/ippb_acc.sv =====
// ----------------------------------------------------------------------------
// ippb_acc
// Target stage: applies the delta to the step target within the soft limits,
// or loads the motor position on a stop, and holds the result beat.
// ----------------------------------------------------------------------------
module ippb_acc import ippb_pkg::*; #(
  parameter int STEP_LIMIT_MAX = 3200,
  parameter int STEP_LIMIT_MIN = -3200
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_vld,
  output logic               up_rdy,
  input  ippb_dlt_t          up_pl,
  output logic               out_vld,
  input  logic               out_rdy,
  output cmd_t               out_cmd,
  output logic signed [15:0] out_target,
  output logic               out_settled
);

  localparam logic signed [16:0] LimMax = 17'(STEP_LIMIT_MAX);
  localparam logic signed [16:0] LimMin = 17'(STEP_LIMIT_MIN);

  logic               vld_r;
  cmd_t               cmd_r;
  logic               settled_r;
  logic signed [15:0] target_r, target_nxt;
  logic signed [16:0] sum;
  logic signed [16:0] clip_hi;
  logic signed [16:0] clip_lo;
  logic               fire;

  assign up_rdy      = !vld_r || out_rdy;
  assign fire        = up_vld && up_rdy;
  assign out_vld     = vld_r;
  assign out_cmd     = cmd_r;
  assign out_target  = target_r;
  assign out_settled = settled_r;

  // New target, clamped to the soft limits.
  assign sum     = 17'(target_r) + 17'(up_pl.delta);
  assign clip_hi = (sum > LimMax) ? LimMax : sum;
  assign clip_lo = (clip_hi < LimMin) ? LimMin : clip_hi;

  always_comb begin
    target_nxt = target_r;
    case (up_pl.ctl.cmd)
      CMD_STOP: begin
        target_nxt = up_pl.ctl.motor;
      end
      CMD_SET: begin
        if (up_pl.ctl.move) begin
          target_nxt = clip_lo[15:0];
        end
      end
      default: begin
        target_nxt = target_r;
      end
    endcase
  end

  // Step target state doubles as the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      target_r <= '0;
    end else begin
      if (up_rdy) begin
        vld_r <= up_vld;
      end
      if (fire) begin
        target_r <= target_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      cmd_r     <= up_pl.ctl.cmd;
      settled_r <= up_pl.ctl.settled;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the incremental PID ball position balancer
// Drives control ticks through the input stream and checks every result beat
// against a cycle-free model of the loop kept inside the bench. A short
// directed table covers reset behavior, frame loss and the delta and step
// clamps. Random phases follow under changing gains, setpoints and limits.
// ----------------------------------------------------------------------------
module tb;
  import ippb_pkg::*;

  localparam int StepMax     = 3200;
  localparam int StepMin     = -3200;
  localparam int SettleLimit = 20;
  localparam int LossLimit   = 12;
  localparam int Latency     = 8;
  localparam int HoldCycles  = 300;
  localparam int QuietLimit  = 4000;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  // Expected content of one result beat.
  typedef struct packed {
    cmd_t               cmd;
    logic signed [15:0] step;
    logic               settled;
  } tick_result_t;

  // One row of the directed table: a register write or a tick.
  typedef struct packed {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic                ok;
    logic [15:0]         ball;
    logic [15:0]         motor;
    bit                  typed;
    tick_result_t        res;
  } plan_row_t;

  typedef enum {EP_CALM, EP_TRACK, EP_LOSS, EP_NOISE} episode_e;
  typedef enum {TUNE_HIGH, TUNE_LOW, TUNE_CROSSED, TUNE_RANDOM} tune_e;
  typedef enum {RX_OPEN, RX_SPARSE, RX_BLINK, RX_COIN} rx_mode_e;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_tvalid;
  logic                in_tready;
  logic [31:0]         in_tdata;   // [15:0] ball_position, [31:16] motor_position
  logic                in_tuser;   // [0] frame_ok
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [23:0]         out_tdata;  // [15:0] step_target, [16] settled, rest zero
  logic [1:0]          out_tuser;  // [1:0] command

  incremental_pid_position_balance DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Loop model: register copies and loop state.
  logic [15:0]        kp = '0, ki = '0, kd = '0;
  logic signed [15:0] setpoint = 16'sd6400;
  logic [14:0]        hold_band = 15'd256;
  logic [14:0]        step_up_max = 15'd100;
  logic signed [15:0] step_down_min = -16'sd100;
  logic signed [16:0] err0 = '0, err1 = '0, err2 = '0;
  logic signed [15:0] held_target = '0;
  logic [3:0]         miss_run = '0;
  logic [7:0]         calm_run = '0;

  tick_result_t due_results[$];
  plan_row_t    plan[$];

  int       fail_count = 0;
  int       checked = 0;
  int       sent_ticks = 0;
  int       settings_used = 1;
  int       stops_seen = 0, settled_seen = 0, rail_seen = 0;
  int       burst_left = 0;
  int       quiet_cycles = 0;
  bit       hold_req = 1'b0;
  episode_e ep_kind = EP_TRACK;
  int       ep_left = 0;
  longint   track_off = 0;

  // Advance the loop model by one tick and return the result it must give.
  function automatic tick_result_t pid_tick(input logic ok, input logic signed [15:0] ball,
                                            input logic signed [15:0] motor);
    tick_result_t r;
    longint err, mag, sum, dlt, nt, e0, e1, e2;
    r.cmd = CMD_NONE;
    if (!ok) begin
      if (miss_run != 4'd15) miss_run++;
      if (miss_run >= LossLimit) begin
        r.cmd = CMD_STOP;
        held_target = motor;
      end
    end else begin
      err = longint'(setpoint) - longint'(ball);
      mag = (err < 0) ? -err : err;
      miss_run = '0;
      if (mag < longint'(hold_band)) begin
        if (calm_run != 8'd255) calm_run++;
        r.cmd = CMD_SET;
      end else begin
        err2 = err1;
        err1 = err0;
        err0 = err[16:0];
        e0 = err0;
        e1 = err1;
        e2 = err2;
        sum = longint'(kp) * (e0 - e1) + longint'(ki) * e0
            + longint'(kd) * (e0 - 2 * e1 + e2);
        // Whole steps, truncated toward zero, then the two delta bounds.
        dlt = sum / 65536;
        if (dlt > longint'(step_up_max)) dlt = step_up_max;
        if (dlt < longint'(step_down_min)) dlt = step_down_min;
        nt = longint'(held_target) + dlt;
        if (nt > StepMax) nt = StepMax;
        if (nt < StepMin) nt = StepMin;
        held_target = nt[15:0];
        calm_run = '0;
        r.cmd = CMD_SET;
      end
    end
    r.step = held_target;
    r.settled = (calm_run >= SettleLimit);
    return r;
  endfunction

  function automatic void pid_config(input logic [CfgIdxW-1:0] idx,
                                     input logic [CfgDataW-1:0] data);
    case (idx)
      REG_GAIN_P: kp = data;
      REG_GAIN_I: ki = data;
      REG_GAIN_D: kd = data;
      REG_TARGET_POSITION: begin
        setpoint = data;
        calm_run = '0;
      end
      REG_DEADBAND:  hold_band = data[14:0];
      REG_DELTA_MAX: step_up_max = data[14:0];
      REG_DELTA_MIN: step_down_min = data;
      default: ;
    endcase
  endfunction

  function automatic int rand_span(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Ball position that gives the requested error, saturated to the field.
  function automatic logic [15:0] ball_for_error(input longint off);
    longint b;
    b = longint'(setpoint) - off;
    if (b > 32767) b = 32767;
    if (b < -32768) b = -32768;
    return b[15:0];
  endfunction

  function automatic logic [15:0] pick_gain();
    if ($urandom_range(0, 7) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 1536));
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    fail_count++;
    if (fail_count <= 10)
      $display("Mismatch on %s at result %0d: expected %0d, got %0d",
               what, checked, want, got);
  endtask

  // Offer one tick, with burst gaps, and record its result once it is taken.
  task automatic push_tick(input logic ok, input logic [15:0] ball, input logic [15:0] motor,
                           input bit typed, input tick_result_t fixed);
    tick_result_t want;
    int           gap;
    want = pid_tick(ok, ball, motor);
    if (typed) want = fixed;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= ok;
    in_tdata  <= {motor, ball};
    do @(posedge clk); while (!in_tready);
    due_results.push_back(want);
    sent_ticks++;
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic settle_out();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    pid_config(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic plan_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    plan.push_back(row);
  endtask

  task automatic plan_tick(input logic ok, input int ball, input int motor, input bit typed,
                           input cmd_t cmd, input int step, input logic settled);
    plan_row_t row;
    row = '0;
    row.ok = ok;
    row.ball = 16'(ball);
    row.motor = 16'(motor);
    row.typed = typed;
    row.res.cmd = cmd;
    row.res.step = 16'(step);
    row.res.settled = settled;
    plan.push_back(row);
  endtask

  // Write a full register setting; the block must be idle.
  task automatic retune(input tune_e style);
    logic [14:0] dmax;
    settings_used++;
    case (style)
      TUNE_HIGH: begin
        apply_reg(REG_GAIN_P, 16'hFFFF);
        apply_reg(REG_GAIN_I, 16'hFFFF);
        apply_reg(REG_GAIN_D, 16'hFFFF);
        apply_reg(REG_TARGET_POSITION, 16'h7FFF);
        apply_reg(REG_DEADBAND, 16'h7FFF);
        apply_reg(REG_DELTA_MAX, 16'h7FFF);
        apply_reg(REG_DELTA_MIN, 16'h8000);
      end
      TUNE_LOW: begin
        apply_reg(REG_GAIN_P, 16'h0000);
        apply_reg(REG_GAIN_I, 16'h0000);
        apply_reg(REG_GAIN_D, 16'h0000);
        apply_reg(REG_TARGET_POSITION, 16'h8000);
        apply_reg(REG_DEADBAND, 16'h0000);
        apply_reg(REG_DELTA_MAX, 16'h0000);
        apply_reg(REG_DELTA_MIN, 16'h0000);
      end
      default: begin
        apply_reg(REG_GAIN_P, pick_gain());
        apply_reg(REG_GAIN_I, pick_gain());
        apply_reg(REG_GAIN_D, pick_gain());
        if ($urandom_range(0, 7) == 0) apply_reg(REG_TARGET_POSITION, 16'($urandom));
        else apply_reg(REG_TARGET_POSITION, 16'(rand_span(-8000, 8000)));
        if ($urandom_range(0, 7) == 0) apply_reg(REG_DEADBAND, 16'($urandom_range(0, 32767)));
        else apply_reg(REG_DEADBAND, 16'($urandom_range(0, 600)));
        if ($urandom_range(0, 7) == 0) dmax = 15'($urandom_range(0, 32767));
        else dmax = 15'($urandom_range(0, 400));
        apply_reg(REG_DELTA_MAX, 16'(dmax));
        // Crossed bounds put the lower bound above the upper one.
        if (style == TUNE_CROSSED)
          apply_reg(REG_DELTA_MIN, 16'(int'(dmax) + rand_span(1, 200)));
        else if ($urandom_range(0, 7) == 0)
          apply_reg(REG_DELTA_MIN, 16'(rand_span(-32768, 0)));
        else
          apply_reg(REG_DELTA_MIN, 16'(rand_span(-400, 0)));
        if ($urandom_range(0, 2) == 0) apply_reg(RegUnused, 16'($urandom));
      end
    endcase
  endtask

  // A phase of random ticks built from episodes of calm, tracking and loss.
  task automatic run_phase(input int n, input bit hold, input bit long_calm);
    logic        ok;
    logic [15:0] ball, motor;
    int          span, pick;
    if (hold) hold_req = 1'b1;
    ep_left = 0;
    if (long_calm) begin
      ep_kind = EP_CALM;
      ep_left = 270;
    end
    repeat (n) begin
      if (ep_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          ep_kind = EP_TRACK;
          ep_left = $urandom_range(5, 40);
        end else if (pick < 65) begin
          ep_kind = EP_CALM;
          ep_left = $urandom_range(5, 40);
        end else if (pick < 85) begin
          ep_kind = EP_LOSS;
          ep_left = $urandom_range(1, 18);
        end else begin
          ep_kind = EP_NOISE;
          ep_left = $urandom_range(1, 4);
        end
      end
      ep_left--;
      ok = 1'b1;
      motor = 16'($urandom);
      case (ep_kind)
        EP_CALM: begin
          if (hold_band > 1) ball = ball_for_error(rand_span(-(int'(hold_band) - 1),
                                                             int'(hold_band) - 1));
          else ball = setpoint;
        end
        EP_TRACK: begin
          span = int'(hold_band) * 4;
          if (span < 2048) span = 2048;
          if (span > 40000) span = 40000;
          if ($urandom_range(0, 9) == 0) track_off = rand_span(-span, span);
          else track_off += rand_span(-span / 6, span / 6);
          if (track_off > 40000) track_off = 40000;
          if (track_off < -40000) track_off = -40000;
          ball = ball_for_error(track_off);
          ok = ($urandom_range(0, 19) != 0);
        end
        EP_LOSS: begin
          ok = 1'b0;
          ball = 16'($urandom);
        end
        default: begin
          ok = 1'($urandom);
          ball = 16'($urandom);
        end
      endcase
      push_tick(ok, ball, motor, 1'b0, '0);
    end
    settle_out();
  endtask

  // Result side: check each beat, then pick the next ready level.
  always @(posedge clk) begin : result_side
    tick_result_t want;
    static int       hold_left = 0;
    static int       rx_cycle = 0;
    static rx_mode_e rx_mode = RX_OPEN;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Mismatch: result beat with nothing outstanding, step_target %0d",
                     $signed(out_tdata[15:0]));
        end else begin
          want = due_results.pop_front();
          if (out_tuser !== want.cmd) flag_mismatch("command", want.cmd, out_tuser);
          if (out_tdata[15:0] !== want.step)
            flag_mismatch("step_target", want.step, $signed(out_tdata[15:0]));
          if (out_tdata[16] !== want.settled)
            flag_mismatch("settled", want.settled, out_tdata[16]);
          if (want.cmd == CMD_STOP) stops_seen++;
          if (want.settled) settled_seen++;
          if (want.step == StepMax || want.step == StepMin) rail_seen++;
          checked++;
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          RX_BLINK:  out_tready <= rx_cycle[2];
          default:   out_tready <= 1'($urandom);
        endcase
      end
    end
  end

  // Watchdog on cycles with no beat on either stream.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, due_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    bit streaming;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero gains, so the held target stays at zero.
    plan_tick(1, 6400, 0, 1, CMD_SET, 0, 0);        // error zero, inside deadband
    plan_tick(1, 6655, 0, 1, CMD_SET, 0, 0);        // just inside deadband
    plan_tick(1, 6656, 0, 1, CMD_SET, 0, 0);        // on the deadband edge
    plan_tick(1, -32768, 0, 1, CMD_SET, 0, 0);
    plan_tick(1, 32767, 0, 1, CMD_SET, 0, 0);
    // Missing frames below the loss limit issue no command.
    repeat (11) plan_tick(0, 16'h5A5A, 1234, 1, CMD_NONE, 0, 0);
    // At the limit the motor position is adopted unclamped.
    plan_tick(0, 0, -32768, 1, CMD_STOP, -32768, 0);
    plan_tick(0, 0, 32767, 1, CMD_STOP, 32767, 0);
    plan_tick(0, 16'hFFFF, 16'h5555, 1, CMD_STOP, 16'h5555, 0);
    plan_tick(1, 6400, 16'hAAAA, 1, CMD_SET, 16'h5555, 0);
    // Crossed delta bounds: the lower bound wins, then the soft upper limit.
    plan_cfg(REG_GAIN_I, 16'hFFFF);
    plan_cfg(REG_DELTA_MAX, 16'd10);
    plan_cfg(REG_DELTA_MIN, 16'd50);
    plan_cfg(RegUnused, 16'hFFFF);
    plan_tick(1, 5400, 0, 1, CMD_SET, StepMax, 0);
    // Widest delta bounds: a large negative delta lands on the soft lower limit.
    plan_cfg(REG_DELTA_MAX, 16'h7FFF);
    plan_cfg(REG_DELTA_MIN, 16'h8000);
    plan_tick(1, 32767, 0, 1, CMD_SET, StepMin, 0);
    plan_cfg(REG_GAIN_P, 16'hFFFF);
    plan_cfg(REG_GAIN_D, 16'hFFFF);
    plan_tick(1, -32768, 0, 0, CMD_NONE, 0, 0);
    plan_tick(1, 0, 0, 0, CMD_NONE, 0, 0);

    streaming = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (streaming) settle_out();
        streaming = 1'b0;
        apply_reg(plan[i].idx, plan[i].data);
      end else begin
        push_tick(plan[i].ok, plan[i].ball, plan[i].motor, plan[i].typed, plan[i].res);
        streaming = 1'b1;
      end
    end
    settle_out();
    settings_used++;

    // Random phases; the hold-off one backs the pipeline up into the input.
    retune(TUNE_HIGH);
    run_phase(80, 1'b0, 1'b0);
    retune(TUNE_LOW);
    run_phase(80, 1'b0, 1'b0);
    retune(TUNE_CROSSED);
    run_phase(80, 1'b0, 1'b0);
    for (int p = 0; p < 7; p++) begin
      retune(TUNE_RANDOM);
      if (p == 5) begin
        // Long calm run drives the settle count into saturation.
        apply_reg(REG_DEADBAND, 16'd400);
        run_phase(320, 1'b0, 1'b1);
      end else begin
        run_phase(90, p == 2, 1'b0);
      end
    end

    $display("Covered %0d ticks under %0d register settings, %0d results checked.",
             sent_ticks, settings_used, checked);
    $display("Seen: %0d stop commands, %0d settled results, %0d targets on a soft limit.",
             stops_seen, settled_seen, rail_seen);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/ippb_pkg.sv
design/ippb_err.sv
design/ippb_mul.sv
design/ippb_dlt.sv
design/ippb_acc.sv
design/incremental_pid_position_balance.sv
tb/tb.sv
